### hdl/rmsd_pkg.sv
// Shared constants for the random multiset sequence draw unit.
package rmsd_pkg;

  // Field widths fixed by the interface
  localparam int RV_W       = 64;
  localparam int JOB_ID_W   = 6;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 8;

  // Iteration counter of the remainder unit, holds 0..RV_W
  localparam int DIV_CNT_W = $clog2(RV_W + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_JOBS     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NUM_MACHINES = CFG_IDX_W'(1);

  // Default pool sizes
  localparam int MAX_JOBS_DEF     = 64;
  localparam int MAX_MACHINES_DEF = 64;

endpackage

### hdl/rmsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rmsd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/rmsd_div.sv
// Restoring remainder unit: 64-bit dividend modulo a narrow divisor, one bit per cycle.
module rmsd_div #(
  parameter int DIV_W = 7
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [rmsd_pkg::RV_W-1:0] dividend,
  input  logic [DIV_W-1:0]         divisor,
  output logic                     done,
  output logic [DIV_W-1:0]         remainder
);

  import rmsd_pkg::*;

  logic                 busy_r;
  logic                 busy_nxt;
  logic                 done_r;
  logic                 done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_CNT_W-1:0] cnt_nxt;
  logic [RV_W-1:0]      q_r;
  logic [RV_W-1:0]      q_nxt;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     rem_nxt;
  logic [DIV_W-1:0]     div_r;
  logic [DIV_W-1:0]     div_nxt;
  logic [DIV_W:0]       trial;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    trial    = {rem_r, q_r[RV_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      q_nxt = {q_r[RV_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[DIV_W-1:0];
      end
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(RV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

### hdl/random_multiset_sequence_draw_unit.sv
// Top level of the random multiset sequence draw unit.
// Draws a job-shop operation sequence in which every job appears num_machines times.
// Input channel: an item (in_random_value, in_restart) transfers at a rising edge with
// start high and busy low. busy stays high until the item's result is issued.
// Result channel: out_valid is high for exactly one cycle with out_job_id,
// out_sequence_last and out_exhausted; the receiver cannot stall it.
// Config channel: cfg_ready is always high; index 0 writes num_jobs, index 1 writes
// num_machines, other indexes are dropped. Writes take effect at the next restart.
// Sequence: a restart first fills the pool memories, one slot per cycle, for the
// effective job count. A draw then runs a check state, the bit-serial remainder unit
// over the 64 dividend bits, a memory read and an update, and, when a job finishes,
// a second read and a move of the last slot into its place.
// An empty pool returns exhausted from the check state without a draw.
// Reset: synchronous active-low rst_n empties the pool and sets both registers to 1;
// the pool memories are not cleared, since only slots below the active count are read.
module random_multiset_sequence_draw_unit #(
  parameter int MAX_JOBS     = rmsd_pkg::MAX_JOBS_DEF,
  parameter int MAX_MACHINES = rmsd_pkg::MAX_MACHINES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [rmsd_pkg::RV_W-1:0]      in_random_value,
  input  logic                           in_restart,
  output logic                           out_valid,
  output logic [rmsd_pkg::JOB_ID_W-1:0]  out_job_id,
  output logic                           out_sequence_last,
  output logic                           out_exhausted,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rmsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rmsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  import rmsd_pkg::*;

  localparam int AW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam int RW = $clog2(MAX_MACHINES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_RD1  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_RD2  = 3'd6;
  localparam logic [2:0] S_MOVE = 3'd7;

  logic [2:0]            state_r;
  logic [2:0]            state_nxt;
  logic [CFG_DATA_W-1:0] num_jobs_r;
  logic [CFG_DATA_W-1:0] num_machines_r;
  logic [CW-1:0]         active_r;
  logic [CW-1:0]         active_nxt;
  logic [AW-1:0]         fill_r;
  logic [AW-1:0]         fill_nxt;
  logic [RW-1:0]         macs_r;
  logic [RW-1:0]         macs_nxt;
  logic [AW-1:0]         idx_r;
  logic [AW-1:0]         idx_nxt;
  logic [AW-1:0]         job_r;
  logic [AW-1:0]         job_nxt;
  logic [RV_W-1:0]       rv_r;
  logic [RV_W-1:0]       rv_nxt;
  logic                  ov_r;
  logic                  ov_nxt;
  logic [JOB_ID_W-1:0]   oj_r;
  logic [JOB_ID_W-1:0]   oj_nxt;
  logic                  ol_r;
  logic                  ol_nxt;
  logic                  oe_r;
  logic                  oe_nxt;

  logic [CW-1:0] jobs_eff;
  logic [RW-1:0] macs_eff;
  logic [RW-1:0] rem_dec;
  logic [CW-1:0] active_m1;

  logic          div_start;
  logic          div_done;
  logic [CW-1:0] div_rem;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [RW-1:0] rem_wdata;
  logic [AW-1:0] job_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [RW-1:0] rem_rdata;
  logic [AW-1:0] job_rdata;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_jobs_r     <= CFG_DATA_W'(1);
      num_machines_r <= CFG_DATA_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_NUM_JOBS) begin
        num_jobs_r <= cfg_data;
      end else if (cfg_index == REG_NUM_MACHINES) begin
        num_machines_r <= cfg_data;
      end
    end
  end

  // Saturate the register values to the pool size; zero machines gives zero jobs
  always_comb begin
    if (int'(num_machines_r) > MAX_MACHINES) begin
      macs_eff = RW'(MAX_MACHINES);
    end else begin
      macs_eff = RW'(num_machines_r);
    end
    if (int'(num_jobs_r) > MAX_JOBS) begin
      jobs_eff = CW'(MAX_JOBS);
    end else begin
      jobs_eff = CW'(num_jobs_r);
    end
    if (macs_eff == '0) begin
      jobs_eff = '0;
    end
  end

  assign active_m1 = active_r - CW'(1);
  assign rem_dec   = (rem_rdata != '0) ? rem_rdata - RW'(1) : '0;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    fill_nxt   = fill_r;
    macs_nxt   = macs_r;
    idx_nxt    = idx_r;
    job_nxt    = job_r;
    rv_nxt     = rv_r;
    ov_nxt     = 1'b0;
    oj_nxt     = oj_r;
    ol_nxt     = ol_r;
    oe_nxt     = oe_r;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    rem_wdata  = rem_dec;
    job_wdata  = job_rdata;
    mem_re     = 1'b0;
    mem_raddr  = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          rv_nxt = in_random_value;
          if (in_restart) begin
            active_nxt = jobs_eff;
            macs_nxt   = macs_eff;
            fill_nxt   = '0;
            state_nxt  = (jobs_eff != '0) ? S_FILL : S_CHK;
          end else begin
            state_nxt = S_CHK;
          end
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_r;
        rem_wdata = macs_r;
        job_wdata = fill_r;
        fill_nxt  = fill_r + AW'(1);
        if (CW'(fill_r) == active_m1) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (active_r == '0) begin
          ov_nxt    = 1'b1;
          oj_nxt    = '0;
          ol_nxt    = 1'b0;
          oe_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          idx_nxt   = AW'(div_rem);
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        mem_re    = 1'b1;
        mem_raddr = idx_r;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        job_nxt = job_rdata;
        if (rem_dec != '0) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r;
          rem_wdata = rem_dec;
          job_wdata = job_rdata;
          ov_nxt    = 1'b1;
          oj_nxt    = JOB_ID_W'(job_rdata);
          ol_nxt    = 1'b0;
          oe_nxt    = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RD2;
        end
      end
      S_RD2: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(active_m1);
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        // move the last active slot into the hole
        mem_we     = 1'b1;
        mem_waddr  = idx_r;
        rem_wdata  = rem_rdata;
        job_wdata  = job_rdata;
        active_nxt = active_m1;
        ov_nxt     = 1'b1;
        oj_nxt     = JOB_ID_W'(job_r);
        ol_nxt     = (active_m1 == '0);
        oe_nxt     = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_r <= fill_nxt;
    macs_r <= macs_nxt;
    idx_r  <= idx_nxt;
    job_r  <= job_nxt;
    rv_r   <= rv_nxt;
    oj_r   <= oj_nxt;
    ol_r   <= ol_nxt;
    oe_r   <= oe_nxt;
  end

  // Remainder unit: random value modulo the active job count
  rmsd_div #(
    .DIV_W(CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rv_r),
    .divisor  (active_r),
    .done     (div_done),
    .remainder(div_rem)
  );

  // Pool memories
  rmsd_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_JOBS)
  ) u_rem_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(rem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(rem_rdata)
  );

  rmsd_ram #(
    .WIDTH(AW),
    .DEPTH(MAX_JOBS)
  ) u_job_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(job_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(job_rdata)
  );

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = ov_r;
  assign out_job_id        = oj_r;
  assign out_sequence_last = ol_r;
  assign out_exhausted     = oe_r;

endmodule
